>>> design/rpb_pkg.sv
package rpb_pkg;

	typedef logic [7:0] chan_t;
	typedef logic [3:0] kind_t;
	typedef logic signed [8:0] operand_t;
	typedef logic [1:0] cfg_index_t;

	localparam int NUM_LANES = 3;
	localparam chan_t CHAN_MAX = 8'd255;

	// Blend mode codes carried in the kind field.
	localparam kind_t KIND_MUL    = 4'd0;
	localparam kind_t KIND_SCREEN = 4'd1;
	localparam kind_t KIND_SUB    = 4'd2;
	localparam kind_t KIND_OVER   = 4'd3;
	localparam kind_t KIND_ADD    = 4'd4;
	localparam kind_t KIND_SCALE  = 4'd5;
	localparam kind_t KIND_NEG    = 4'd6;
	localparam kind_t KIND_REP_B  = 4'd7;
	localparam kind_t KIND_REP_G  = 4'd8;
	localparam kind_t KIND_REP_R  = 4'd9;
	localparam kind_t KIND_INS_B  = 4'd10;
	localparam kind_t KIND_INS_G  = 4'd11;
	localparam kind_t KIND_INS_R  = 4'd12;

	// Register indexes on the configuration channel.
	localparam cfg_index_t CFG_BLUE  = 2'd0;
	localparam cfg_index_t CFG_GREEN = 2'd1;
	localparam cfg_index_t CFG_RED   = 2'd2;

	// How the last stage forms a channel.
	typedef enum logic [1:0] {
		POST_DIRECT,
		POST_SCALE,
		POST_Q,
		POST_INVQ
	} post_t;

	// Which value the first stage puts on the direct path.
	typedef enum logic [1:0] {
		DSEL_COPY,
		DSEL_SUB,
		DSEL_ADD
	} dsel_t;

	typedef struct packed {
		logic  inv;
		logic  use_op;
		logic  dbl;
		post_t post;
		dsel_t dsel;
	} lane_ctl_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

>>> design/rpb_if.sv
interface rpb_pix_in_if;
	import rpb_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	chan_t top_blue;
	chan_t top_green;
	chan_t top_red;
	chan_t bottom_blue;
	chan_t bottom_green;
	chan_t bottom_red;

	modport source (
		output valid, kind, top_blue, top_green, top_red,
		output bottom_blue, bottom_green, bottom_red,
		input  ready
	);
	modport sink (
		input  valid, kind, top_blue, top_green, top_red,
		input  bottom_blue, bottom_green, bottom_red,
		output ready
	);
endinterface

interface rpb_pix_out_if;
	import rpb_pkg::*;

	logic  valid;
	logic  ready;
	chan_t out_blue;
	chan_t out_green;
	chan_t out_red;

	modport source (output valid, out_blue, out_green, out_red, input ready);
	modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

interface rpb_cfg_if;
	import rpb_pkg::*;

	logic       valid;
	logic       ready;
	cfg_index_t index;
	operand_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/rpb_lane.sv
module rpb_lane (
	input  logic               clk,
	input  rpb_pkg::pipe_en_t  en,
	input  rpb_pkg::lane_ctl_t ctl,
	input  rpb_pkg::chan_t     top_val,
	input  rpb_pkg::chan_t     bot_val,
	input  rpb_pkg::chan_t     copy_val,
	input  rpb_pkg::operand_t  operand,
	output rpb_pkg::chan_t     result
);
	import rpb_pkg::*;

	function automatic chan_t clamp10(input logic signed [9:0] v);
		chan_t r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 10'sd255) begin
			r = CHAN_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Stage 1: operand selection and the simple modes.
	logic signed [9:0] diff;
	logic signed [9:0] sum;
	chan_t             direct0;
	chan_t             mul_a0;
	operand_t          mul_b0;

	always_comb begin
		diff   = $signed({2'b00, bot_val}) - $signed({2'b00, top_val});
		sum    = $signed({2'b00, top_val}) + $signed({operand[8], operand});
		mul_a0 = ctl.inv ? CHAN_MAX - top_val : top_val;
		mul_b0 = ctl.use_op ? operand :
			$signed({1'b0, (ctl.inv ? CHAN_MAX - bot_val : bot_val)});
		case (ctl.dsel)
			DSEL_SUB: direct0 = clamp10(diff);
			DSEL_ADD: direct0 = clamp10(sum);
			default:  direct0 = copy_val;
		endcase
	end

	chan_t     mul_a_s1;
	operand_t  mul_b_s1;
	chan_t     direct_s1;
	lane_ctl_t ctl_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mul_a_s1  <= mul_a0;
			mul_b_s1  <= mul_b0;
			direct_s1 <= direct0;
			ctl_s1    <= ctl;
		end
	end

	// Stage 2: one signed 9x9 multiply.
	logic signed [17:0] mul_a_w;
	logic signed [17:0] mul_b_w;
	logic signed [17:0] prod_s2;
	chan_t              direct_s2;
	lane_ctl_t          ctl_s2;

	assign mul_a_w = 18'($signed({1'b0, mul_a_s1}));
	assign mul_b_w = 18'(mul_b_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2   <= mul_a_w * mul_b_w;
			direct_s2 <= direct_s1;
			ctl_s2    <= ctl_s1;
		end
	end

	// Stage 3: rounding offset and quotient estimate x*257/65536, which is
	// at most one below floor(x/255). Scale results are clamped here.
	logic [16:0] pm;
	logic [16:0] x3;
	logic [24:0] qsum;
	chan_t       direct3;

	always_comb begin
		pm   = ctl_s2.dbl ? {prod_s2[15:0], 1'b0} : prod_s2[16:0];
		x3   = pm + 17'd127;
		qsum = {x3, 8'b0} + {8'b0, x3};
		if (ctl_s2.post == POST_SCALE) begin
			if (prod_s2[17]) begin
				direct3 = 8'd0;
			end else if (|prod_s2[16:8]) begin
				direct3 = CHAN_MAX;
			end else begin
				direct3 = prod_s2[7:0];
			end
		end else begin
			direct3 = direct_s2;
		end
	end

	logic [16:0] x_s3;
	logic [8:0]  qe_s3;
	chan_t       direct_s3;
	post_t       post_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			x_s3      <= x3;
			qe_s3     <= qsum[24:16];
			direct_s3 <= direct3;
			post_s3   <= ctl_s2.post;
		end
	end

	// Stage 4: one correction step on the quotient, then the channel.
	logic [17:0] rem;
	logic [8:0]  q;
	chan_t       res4;

	always_comb begin
		rem = {1'b0, x_s3} + {9'b0, qe_s3} - {1'b0, qe_s3, 8'b0};
		q   = qe_s3 + 9'(rem >= 18'd255);
		case (post_s3)
			POST_Q:    res4 = q[7:0];
			POST_INVQ: res4 = q[8] ? 8'd0 : CHAN_MAX - q[7:0];
			default:   res4 = direct_s3;
		endcase
	end

	chan_t res_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4 <= res4;
		end
	end

	assign result = res_s4;

endmodule

>>> design/rgb_pixel_blend_unit_top.sv
// Pixel blend unit: combines a top and a bottom 8-bit BGR pixel into one pixel.
// The pix_in channel carries one request per pixel pair: the mode in kind and
// the six channel values. The pix_out channel returns one blended pixel per
// request, in request order. Both use valid/ready; a transfer happens on a
// rising clock edge with both high.
// The cfg channel writes the three signed per-channel operands used by the add
// and scale modes. It is always ready and should only be written while no
// request is in flight.
// The datapath is a four-stage pipeline: operand select, multiply, rounding
// estimate, correction and output register. A request is registered in each
// stage in turn, and its result shows on pix_out from the output register;
// the unit accepts one request every cycle unless back-pressure has filled
// the pipeline. The multiply stage and the divide-by-255 rounding split across
// stages three and four set the pipeline depth.
// Each stage moves forward whenever the stage after it is empty or moving, so
// a stalled receiver first fills the internal bubbles and only then drops
// pix_in.ready. Nothing is lost or repeated under back-pressure.
// Reset clears all stage valid bits and the operand registers to zero; the
// unit accepts requests in the first cycle after reset is released.
module rgb_pixel_blend_unit_top (
	input logic          clk,
	input logic          arst_n,
	rpb_pix_in_if.sink   pix_in,
	rpb_pix_out_if.source pix_out,
	rpb_cfg_if.sink      cfg
);
	import rpb_pkg::*;

	// Operand registers, one per channel in blue, green, red order.
	operand_t op_q [NUM_LANES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '{default: '0};
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BLUE:  op_q[0] <= cfg.data;
				CFG_GREEN: op_q[1] <= cfg.data;
				CFG_RED:   op_q[2] <= cfg.data;
				default:   ;
			endcase
		end
	end

	// Stage valid bits and the ready chain. A stage may load when it is
	// empty or when its contents move on in the same cycle.
	logic     v_s1, v_s2, v_s3, v_s4;
	pipe_en_t en;

	always_comb begin
		en.s4 = !v_s4 || pix_out.ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= pix_in.valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign pix_in.ready  = en.s1;
	assign pix_out.valid = v_s4;

	// Mode decode. Overlay looks at the whole bottom pixel to choose between
	// doubled multiply and doubled screen, so that decision is made here.
	chan_t     tv [NUM_LANES];
	chan_t     bv [NUM_LANES];
	chan_t     copy_v [NUM_LANES];
	lane_ctl_t ctl [NUM_LANES];
	logic      dark;

	assign tv[0] = pix_in.top_blue;
	assign tv[1] = pix_in.top_green;
	assign tv[2] = pix_in.top_red;
	assign bv[0] = pix_in.bottom_blue;
	assign bv[1] = pix_in.bottom_green;
	assign bv[2] = pix_in.bottom_red;

	always_comb begin
		dark = !bv[0][7] && !bv[1][7] && !bv[2][7];
		for (int c = 0; c < NUM_LANES; c++) begin
			ctl[c]    = '{inv: 1'b0, use_op: 1'b0, dbl: 1'b0,
				post: POST_DIRECT, dsel: DSEL_COPY};
			copy_v[c] = bv[c];
			case (pix_in.kind)
				KIND_MUL: begin
					ctl[c].post = POST_Q;
				end
				KIND_SCREEN: begin
					ctl[c].inv  = 1'b1;
					ctl[c].post = POST_INVQ;
				end
				KIND_SUB: begin
					ctl[c].dsel = DSEL_SUB;
				end
				KIND_OVER: begin
					ctl[c].dbl  = 1'b1;
					ctl[c].inv  = !dark;
					ctl[c].post = dark ? POST_Q : POST_INVQ;
				end
				KIND_ADD: begin
					ctl[c].dsel = DSEL_ADD;
				end
				KIND_SCALE: begin
					ctl[c].use_op = 1'b1;
					ctl[c].post   = POST_SCALE;
				end
				KIND_NEG: begin
					copy_v[c] = CHAN_MAX - tv[c];
				end
				KIND_REP_B: begin
					copy_v[c] = tv[0];
				end
				KIND_REP_G: begin
					copy_v[c] = tv[1];
				end
				KIND_REP_R: begin
					copy_v[c] = tv[2];
				end
				KIND_INS_B, KIND_INS_G, KIND_INS_R: begin
					if (pix_in.kind == kind_t'(int'(KIND_INS_B) + c)) begin
						copy_v[c] = tv[c];
					end
				end
				default: begin
					copy_v[c] = bv[c];
				end
			endcase
		end
	end

	chan_t res [NUM_LANES];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		rpb_lane u_lane (
			.clk      (clk),
			.en       (en),
			.ctl      (ctl[g]),
			.top_val  (tv[g]),
			.bot_val  (bv[g]),
			.copy_val (copy_v[g]),
			.operand  (op_q[g]),
			.result   (res[g])
		);
	end

	assign pix_out.out_blue  = res[0];
	assign pix_out.out_green = res[1];
	assign pix_out.out_red   = res[2];

endmodule

>>> design/rpb_checker.sv
module rpb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input rpb_pkg::chan_t out_blue,
	input rpb_pkg::chan_t out_green,
	input rpb_pkg::chan_t out_red
);
	import rpb_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// The output register is empty while reset is held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// A result waiting on the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red))
		else $error("stalled result changed or dropped");

	// Requests are refused only when a result is stuck at the output.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without back-pressure");

	// With the receiver ready throughout, a request's result reaches the output
	// once it has passed through the stage registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind rgb_pixel_blend_unit_top rpb_checker u_rpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_blue  (pix_out.out_blue),
	.out_green (pix_out.out_green),
	.out_red   (pix_out.out_red)
);
